/* rtl/fbfl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fixed block free list allocator.
// Used by fbfl_ctrl, fbfl_dpath and fixed_block_free_list_allocator; no dependencies.
package fbfl_pkg;

    localparam int CNT_W     = 9;
    localparam int SIZE_W    = 13;
    localparam int IDX_W     = 8;
    localparam int OFS_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 13;
    localparam int ENTRY_W   = IDX_W + 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE  = 1'b1;

    localparam logic [CNT_W-1:0]  COUNT_RST = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_RST  = 13'd64;

    // operation codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NULL_FREE = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic             func;
        logic             block_is_null;
        logic [IDX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] granted_index;
        logic [OFS_W-1:0] byte_offset;
        logic             pool_empty;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_APPLY,
        S_REPLY
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic apply;
        logic reply;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic alloc_pending;
    } sts_t;

endpackage

/* rtl/fbfl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for one allocator beat: capture, table lookup, head update, reply.
// Depends on fbfl_pkg.
module fbfl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fbfl_pkg::sts_t   sts,
    output fbfl_pkg::ctl_t   ctl,
    output logic             busy
);

    fbfl_pkg::state_t state_reg;
    fbfl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbfl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = fbfl_pkg::S_LOOKUP;
                end
            end
            fbfl_pkg::S_LOOKUP: state_next = fbfl_pkg::S_APPLY;
            fbfl_pkg::S_APPLY:  state_next = fbfl_pkg::S_REPLY;
            fbfl_pkg::S_REPLY:  state_next = fbfl_pkg::S_IDLE;
            default:            state_next = fbfl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        case (state_reg)
            fbfl_pkg::S_IDLE:
            begin
                busy        = 1'b0;
                ctl.capture = start;
            end
            // only an allocate needs the successor of the head
            fbfl_pkg::S_LOOKUP: ctl.lookup = sts.alloc_pending;
            fbfl_pkg::S_APPLY:  ctl.apply  = 1'b1;
            fbfl_pkg::S_REPLY:  ctl.reply  = 1'b1;
            default:            busy       = 1'b1;
        endcase
    end

endmodule

/* rtl/fbfl_dpath.sv */
`timescale 1ns / 1ps
// Datapath: configuration registers, free list head, next-link table, offset multiply.
// Depends on fbfl_pkg.
module fbfl_dpath #(
    parameter int POOL_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fbfl_pkg::ctl_t                    ctl,
    output fbfl_pkg::sts_t                    sts,
    input  fbfl_pkg::req_t                    request,
    output fbfl_pkg::rsp_t                    result,
    input  logic                              cfg_write,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fbfl_pkg::CFG_W-1:0]        cfg_data
);

    // the 8-bit index fields never reach past 256 entries
    localparam int TBL_DEPTH = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int PROD_W    = fbfl_pkg::IDX_W + fbfl_pkg::SIZE_W;
    localparam logic [fbfl_pkg::CNT_W-1:0] TBL_CNT = fbfl_pkg::CNT_W'(TBL_DEPTH);

    logic [fbfl_pkg::CNT_W-1:0]   count_reg;
    logic [fbfl_pkg::SIZE_W-1:0]  size_reg;
    logic [fbfl_pkg::IDX_W-1:0]   head_reg;
    logic [fbfl_pkg::IDX_W-1:0]   head_next;
    logic                         head_valid_reg;
    logic                         head_valid_next;
    fbfl_pkg::req_t               op_reg;
    fbfl_pkg::rsp_t               rsp_reg;
    fbfl_pkg::rsp_t               rsp_next;
    logic [TBL_DEPTH-1:0]         written_reg;
    logic                         hit_reg;
    logic [fbfl_pkg::ENTRY_W-1:0] rd_data_reg;

    // next-link table: valid bit on top, successor index below
    logic [fbfl_pkg::ENTRY_W-1:0] link_mem [TBL_DEPTH];

    logic [fbfl_pkg::CNT_W-1:0]   n_eff;
    logic [fbfl_pkg::CNT_W-1:0]   n_new;
    logic [fbfl_pkg::CNT_W-1:0]   succ;
    logic [fbfl_pkg::ENTRY_W-1:0] link;
    logic [PROD_W-1:0]            product;
    logic                         free_ok;
    logic                         count_wr;

    assign count_wr = cfg_write && (cfg_index == fbfl_pkg::REG_ELEMENT_COUNT);
    assign n_eff    = (count_reg > TBL_CNT) ? TBL_CNT : count_reg;
    assign n_new    = (cfg_data[fbfl_pkg::CNT_W-1:0] > TBL_CNT) ? TBL_CNT
                                                                 : cfg_data[fbfl_pkg::CNT_W-1:0];

    assign sts.alloc_pending = (op_reg.func == fbfl_pkg::FN_ALLOC) && head_valid_reg;

    // a link never written since the last rebuild reads as the chained default
    assign succ    = {1'b0, head_reg} + fbfl_pkg::CNT_W'(1);
    assign link    = hit_reg ? rd_data_reg
                             : {(succ < n_eff), succ[fbfl_pkg::IDX_W-1:0]};
    assign product = PROD_W'(head_reg) * PROD_W'(size_reg);
    assign free_ok = !op_reg.block_is_null && ({1'b0, op_reg.block_index} < n_eff);

    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        rsp_next        = '0;
        if (op_reg.func == fbfl_pkg::FN_ALLOC)
        begin
            if (!head_valid_reg)
            begin
                rsp_next.status = fbfl_pkg::ST_EMPTY;
            end
            else
            begin
                rsp_next.status        = fbfl_pkg::ST_OK;
                rsp_next.granted_index = head_reg;
                rsp_next.byte_offset   = product[fbfl_pkg::OFS_W-1:0];
                head_next              = link[fbfl_pkg::IDX_W-1:0];
                head_valid_next        = link[fbfl_pkg::IDX_W];
            end
        end
        else if (op_reg.block_is_null)
        begin
            rsp_next.status = fbfl_pkg::ST_NULL_FREE;
        end
        else if (!free_ok)
        begin
            rsp_next.status = fbfl_pkg::ST_RANGE;
        end
        else
        begin
            rsp_next.status = fbfl_pkg::ST_OK;
            head_next       = op_reg.block_index;
            head_valid_next = 1'b1;
        end
        rsp_next.pool_empty = !head_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= fbfl_pkg::COUNT_RST;
            size_reg       <= fbfl_pkg::SIZE_RST;
            head_reg       <= '0;
            head_valid_reg <= 1'b1;
            written_reg    <= '0;
        end
        else if (count_wr)
        begin
            // rebuild: head back to block 0, every link reverts to its default
            count_reg      <= cfg_data[fbfl_pkg::CNT_W-1:0];
            head_reg       <= '0;
            head_valid_reg <= (n_new != '0);
            written_reg    <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == fbfl_pkg::REG_ELEMENT_SIZE))
            begin
                size_reg <= cfg_data[fbfl_pkg::SIZE_W-1:0];
            end
            if (ctl.apply)
            begin
                head_reg       <= head_next;
                head_valid_reg <= head_valid_next;
                if ((op_reg.func == fbfl_pkg::FN_FREE) && free_ok)
                begin
                    written_reg[op_reg.block_index[AW-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg <= request;
        end
        if (ctl.lookup)
        begin
            rd_data_reg <= link_mem[head_reg[AW-1:0]];
            hit_reg     <= written_reg[head_reg[AW-1:0]];
        end
        if (ctl.apply)
        begin
            rsp_reg <= rsp_next;
            // push: old head becomes the freed block's successor
            if ((op_reg.func == fbfl_pkg::FN_FREE) && free_ok)
            begin
                link_mem[op_reg.block_index[AW-1:0]] <= {head_valid_reg, head_reg};
            end
        end
    end

    assign result = rsp_reg;

endmodule

/* rtl/fixed_block_free_list_allocator.sv */
`timescale 1ns / 1ps
// Top level of the fixed block free list allocator: controller plus datapath.
// Depends on fbfl_pkg, fbfl_ctrl and fbfl_dpath.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+-----------------------------
//   request  | request (func, block_is_null, idx) | start high while busy low
//   result   | result (status, index, offset, ..) | done high for one cycle
//   config   | cfg_write, cfg_index, cfg_data     | cfg_write high, no wait
//
// Each beat runs through these steps in order up to the done strobe: accept, one
// registered read of the next-link table, head update with the offset multiply,
// reply. busy stays high until the done cycle ends. Reset, and any write of
// element_count, rebuild the free list at once through per-entry written bits;
// there is no clearing pass. The receiver cannot stall the result.
module fixed_block_free_list_allocator #(
    parameter int POOL_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  fbfl_pkg::req_t                 request,
    output logic                           done,
    output fbfl_pkg::rsp_t                 result,
    input  logic                           cfg_write,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbfl_pkg::CFG_W-1:0]     cfg_data
);

    fbfl_pkg::ctl_t ctl;
    fbfl_pkg::sts_t sts;

    fbfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    fbfl_dpath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .request   (request),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign done = ctl.reply;

endmodule
